// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
// Expects signals clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rsb_pkg.sv -----
// Package for the RLE sprite blitter: widths, codes, config record, helpers.
// No dependencies.
`default_nettype none

package rsb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ADDR_BITS_DEF  = 24;
    localparam int PIXEL_BITS     = 8;
    localparam int POS_BITS       = 16;
    localparam int WIN_POS_W      = 12;
    localparam int WIN_SIZE_W     = 13;
    localparam int SCR_W          = 13;   // on-screen coordinate after clipping
    localparam int ORG_W          = 18;   // window corner plus signed position
    localparam int RUN_W          = 7;
    localparam int CFG_DATA_W     = 13;
    localparam int REG_IDX_W      = 3;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WINDOW_X      = 3'd0,
        REG_WINDOW_Y      = 3'd1,
        REG_WINDOW_WIDTH  = 3'd2,
        REG_WINDOW_HEIGHT = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_FLIP_H        = 3'd5,
        REG_FLIP_V        = 3'd6,
        REG_BLEND_MODE    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        BLEND_SOLID     = 2'd0,
        BLEND_GLASS_SRC = 2'd1,
        BLEND_GLASS_DST = 2'd2
    } blend_t;

    typedef struct packed {
        logic [WIN_POS_W-1:0]  win_x;
        logic [WIN_POS_W-1:0]  win_y;
        logic [WIN_SIZE_W-1:0] win_w;
        logic [WIN_SIZE_W-1:0] win_h;
        logic [WIN_SIZE_W-1:0] scr_w;
        logic                  flip_h;
        logic                  flip_v;
        logic [1:0]            blend;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        win_x:  '0,
        win_y:  '0,
        win_w:  13'd320,
        win_h:  13'd200,
        scr_w:  13'd320,
        flip_h: 1'b0,
        flip_v: 1'b0,
        blend:  2'd0
    };

    // signed width of sprite origin plus mirrored offset
    function automatic int sx_width(int coord_bits);
        return ((coord_bits + 1) > ORG_W ? (coord_bits + 1) : ORG_W) + 1;
    endfunction

    // unused blend code falls back to a plain copy
    function automatic blend_t blend_code(logic [1:0] mode);
        blend_t op;
        unique case (mode)
            BLEND_GLASS_SRC: op = BLEND_GLASS_SRC;
            BLEND_GLASS_DST: op = BLEND_GLASS_DST;
            default:         op = BLEND_SOLID;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rsb_if.sv -----
// Valid/ready channel interfaces for sprite items and framebuffer writes.
// Depends on rsb_pkg.
`default_nettype none

interface rsb_in_if #(
    parameter int COORD_BITS = rsb_pkg::COORD_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic signed [rsb_pkg::POS_BITS-1:0] pos_x;
    logic signed [rsb_pkg::POS_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0]              sprite_width;
    logic [COORD_BITS-1:0]              sprite_height;
    logic [rsb_pkg::PIXEL_BITS-1:0]     data_byte;

    modport source (output valid, mode, pos_x, pos_y, sprite_width, sprite_height,
                    data_byte, input ready);
    modport sink   (input valid, mode, pos_x, pos_y, sprite_width, sprite_height,
                    data_byte, output ready);
endinterface

interface rsb_out_if #(
    parameter int ADDR_BITS = rsb_pkg::ADDR_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [ADDR_BITS-1:0]           address;
    logic [rsb_pkg::PIXEL_BITS-1:0] pixel;
    logic [1:0]                     blend_op;

    modport source (output valid, address, pixel, blend_op, input ready);
    modport sink   (input valid, address, pixel, blend_op, output ready);
endinterface

`default_nettype wire

// ----- sv/rle_sprite_blitter.sv -----
// RLE sprite blitter: decodes run-length sprite bytes into clipped framebuffer writes.
// A decoded pixel passes the parser register, clip stage and result register in order.
// Throughput: one item per cycle unless results stall; these registers each hold one
// transaction and advance independently under backpressure.
// Reset (rst_n, async, active low): no sprite active, pipeline empty, window 0,0
// 320x200, stride 320, no flip, solid copy.
`default_nettype none

module rle_sprite_blitter #(
    parameter int COORD_BITS = rsb_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = rsb_pkg::ADDR_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    rsb_in_if.sink                               items,
    rsb_out_if.source                            results,
    input  wire logic                            wr_en,
    input  wire logic [rsb_pkg::REG_IDX_W-1:0]   wr_index,
    input  wire logic [rsb_pkg::CFG_DATA_W-1:0]  wr_data
);

    localparam int SX_W = rsb_pkg::sx_width(COORD_BITS);

    rsb_pkg::cfg_t cfg_reg;

    logic                           cand_valid;
    logic                           cand_ready;
    logic signed [SX_W-1:0]         cand_sx, cand_sy;
    logic [rsb_pkg::PIXEL_BITS-1:0] cand_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rsb_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (rsb_pkg::reg_idx_t'(wr_index))
                rsb_pkg::REG_WINDOW_X:      cfg_reg.win_x  <= wr_data[rsb_pkg::WIN_POS_W-1:0];
                rsb_pkg::REG_WINDOW_Y:      cfg_reg.win_y  <= wr_data[rsb_pkg::WIN_POS_W-1:0];
                rsb_pkg::REG_WINDOW_WIDTH:  cfg_reg.win_w  <= wr_data[rsb_pkg::WIN_SIZE_W-1:0];
                rsb_pkg::REG_WINDOW_HEIGHT: cfg_reg.win_h  <= wr_data[rsb_pkg::WIN_SIZE_W-1:0];
                rsb_pkg::REG_SCREEN_WIDTH:  cfg_reg.scr_w  <= wr_data[rsb_pkg::WIN_SIZE_W-1:0];
                rsb_pkg::REG_FLIP_H:        cfg_reg.flip_h <= wr_data[0];
                rsb_pkg::REG_FLIP_V:        cfg_reg.flip_v <= wr_data[0];
                rsb_pkg::REG_BLEND_MODE:    cfg_reg.blend  <= wr_data[1:0];
            endcase
        end
    end

    rsb_parser #(
        .COORD_BITS (COORD_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cfg        (cfg_reg),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand_sx    (cand_sx),
        .cand_sy    (cand_sy),
        .cand_pixel (cand_pixel)
    );

    rsb_place #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_place (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand_sx    (cand_sx),
        .cand_sy    (cand_sy),
        .cand_pixel (cand_pixel),
        .results    (results)
    );

endmodule

`default_nettype wire

// ----- sv/rsb_parser.sv -----
// Token parser: sprite state, run decoding, mirroring; registers one candidate
// pixel (absolute position) per in-sprite run byte. Depends on rsb_pkg, rsb_if.
`default_nettype none

module rsb_parser #(
    parameter int COORD_BITS = rsb_pkg::COORD_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    rsb_in_if.sink                                      items,
    input  wire rsb_pkg::cfg_t                          cfg,
    output logic                                        cand_valid,
    input  wire logic                                   cand_ready,
    output logic signed [rsb_pkg::sx_width(COORD_BITS)-1:0] cand_sx,
    output logic signed [rsb_pkg::sx_width(COORD_BITS)-1:0] cand_sy,
    output logic [rsb_pkg::PIXEL_BITS-1:0]              cand_pixel
);

    localparam int SX_W  = rsb_pkg::sx_width(COORD_BITS);
    localparam int COL_W = COORD_BITS + 1;
    localparam logic [COL_W-1:0] COL_MAX = '1;

    logic                            active_reg, active_next;
    logic [COORD_BITS-1:0]           row_reg, row_next;
    logic [COL_W-1:0]                col_reg, col_next;
    logic                            in_run_reg, in_run_next;
    logic [rsb_pkg::RUN_W-1:0]       run_reg, run_next;
    logic signed [rsb_pkg::ORG_W-1:0] org_x_reg, org_x_next;
    logic signed [rsb_pkg::ORG_W-1:0] org_y_reg, org_y_next;
    logic [COORD_BITS-1:0]           w_reg, w_next;
    logic [COORD_BITS-1:0]           h_reg, h_next;

    logic                            cand_valid_reg;
    logic signed [SX_W-1:0]          cand_sx_reg, cand_sy_reg;
    logic [rsb_pkg::PIXEL_BITS-1:0]  cand_pixel_reg;

    logic                            accept;
    logic                            emit;
    logic [8:0]                      skip;
    logic [COL_W:0]                  col_skip;
    logic [COORD_BITS-1:0]           col_small;
    logic [COORD_BITS-1:0]           dx, dy;
    logic signed [SX_W-1:0]          sx, sy;

    assign items.ready = !cand_valid_reg || cand_ready;
    assign accept      = items.valid && items.ready;

    assign skip      = 9'(9'd256 - {1'b0, items.data_byte});
    assign col_skip  = {1'b0, col_reg} + (COL_W + 1)'(skip);
    assign col_small = col_reg[COORD_BITS-1:0];

    always_comb
    begin
        active_next = active_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        in_run_next = in_run_reg;
        run_next    = run_reg;
        org_x_next  = org_x_reg;
        org_y_next  = org_y_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        emit        = 1'b0;
        if (accept)
        begin
            if (items.mode == rsb_pkg::MODE_START)
            begin
                org_x_next  = rsb_pkg::ORG_W'($signed({1'b0, cfg.win_x}))
                              + rsb_pkg::ORG_W'(items.pos_x);
                org_y_next  = rsb_pkg::ORG_W'($signed({1'b0, cfg.win_y}))
                              + rsb_pkg::ORG_W'(items.pos_y);
                w_next      = items.sprite_width;
                h_next      = items.sprite_height;
                row_next    = '0;
                col_next    = '0;
                in_run_next = 1'b0;
                run_next    = '0;
                active_next = (items.sprite_width != '0) && (items.sprite_height != '0);
            end
            else if (active_reg)
            begin
                if (in_run_reg)
                begin
                    emit     = (col_reg < {1'b0, w_reg}) && (row_reg < h_reg);
                    col_next = (col_reg != COL_MAX) ? col_reg + 1'b1 : col_reg;
                    run_next = run_reg - 1'b1;
                    if (run_next == '0)
                        in_run_next = 1'b0;
                end
                else if (items.data_byte == '0)
                begin
                    // end of row
                    col_next    = '0;
                    row_next    = row_reg + 1'b1;
                    active_next = !((row_next >= h_reg) || (row_next == '0));
                end
                else if (!items.data_byte[7])
                begin
                    in_run_next = 1'b1;
                    run_next    = items.data_byte[rsb_pkg::RUN_W-1:0];
                end
                else
                begin
                    col_next = (col_skip > (COL_W + 1)'(COL_MAX)) ? COL_MAX
                                                                  : col_skip[COL_W-1:0];
                end
            end
        end
    end

    // column is below the width whenever a pixel is emitted
    assign dx = cfg.flip_h ? (w_reg - 1'b1 - col_small) : col_small;
    assign dy = cfg.flip_v ? (h_reg - 1'b1 - row_reg) : row_reg;
    assign sx = SX_W'(org_x_reg) + SX_W'($signed({1'b0, dx}));
    assign sy = SX_W'(org_y_reg) + SX_W'($signed({1'b0, dy}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            in_run_reg     <= 1'b0;
            run_reg        <= '0;
            org_x_reg      <= '0;
            org_y_reg      <= '0;
            w_reg          <= '0;
            h_reg          <= '0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            in_run_reg <= in_run_next;
            run_reg    <= run_next;
            org_x_reg  <= org_x_next;
            org_y_reg  <= org_y_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            if (items.ready)
                cand_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cand_sx_reg    <= sx;
            cand_sy_reg    <= sy;
            cand_pixel_reg <= items.data_byte;
        end
    end

    assign cand_valid = cand_valid_reg;
    assign cand_sx    = cand_sx_reg;
    assign cand_sy    = cand_sy_reg;
    assign cand_pixel = cand_pixel_reg;

    `include "assert_macros.svh"

    `ASSERT_IMPLIES(a_run_nonzero, in_run_reg, run_reg != '0, "pixel run with zero count")
    `ASSERT_IMPLIES(a_run_needs_active, in_run_reg, active_reg, "pixel run on idle sprite")
    `ASSERT_IMPLIES(a_row_in_range, active_reg, row_reg < h_reg, "row past sprite height")
    `ASSERT_NEXT(a_cand_from_run, accept && !(in_run_reg && active_reg), !$rose(cand_valid_reg),
        "candidate pixel without a pixel run")

endmodule

`default_nettype wire

// ----- sv/rsb_place.sv -----
// Window clip and framebuffer address stages with the result register.
// Depends on rsb_pkg, rsb_if.
`default_nettype none

module rsb_place #(
    parameter int COORD_BITS = rsb_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = rsb_pkg::ADDR_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire rsb_pkg::cfg_t                          cfg,
    input  wire logic                                   cand_valid,
    output logic                                        cand_ready,
    input  wire logic signed [rsb_pkg::sx_width(COORD_BITS)-1:0] cand_sx,
    input  wire logic signed [rsb_pkg::sx_width(COORD_BITS)-1:0] cand_sy,
    input  wire logic [rsb_pkg::PIXEL_BITS-1:0]         cand_pixel,
    rsb_out_if.source                                   results
);

    localparam int SX_W   = rsb_pkg::sx_width(COORD_BITS);
    localparam int END_W  = rsb_pkg::WIN_SIZE_W + 1;
    localparam int PROD_W = rsb_pkg::SCR_W + rsb_pkg::WIN_SIZE_W;
    localparam int SUM_W  = PROD_W + 1;

    logic                           b_valid_reg;
    logic [rsb_pkg::SCR_W-1:0]      b_sx_reg, b_sy_reg;
    logic [rsb_pkg::PIXEL_BITS-1:0] b_pixel_reg;

    logic                           c_valid_reg;
    logic [ADDR_BITS-1:0]           c_addr_reg;
    logic [rsb_pkg::PIXEL_BITS-1:0] c_pixel_reg;
    logic [1:0]                     c_op_reg;

    logic [END_W-1:0]               x_end, y_end;
    logic                           visible;
    logic                           c_ready, b_ready;
    logic [PROD_W-1:0]              prod;
    logic [SUM_W-1:0]               sum;

    assign x_end = {1'b0, (rsb_pkg::WIN_SIZE_W)'(cfg.win_x)} + END_W'(cfg.win_w);
    assign y_end = {1'b0, (rsb_pkg::WIN_SIZE_W)'(cfg.win_y)} + END_W'(cfg.win_h);

    assign visible = (cand_sx >= SX_W'($signed({1'b0, cfg.win_x})))
                  && (cand_sx <  SX_W'($signed({1'b0, x_end})))
                  && (cand_sy >= SX_W'($signed({1'b0, cfg.win_y})))
                  && (cand_sy <  SX_W'($signed({1'b0, y_end})));

    assign c_ready    = !c_valid_reg || results.ready;
    assign b_ready    = !b_valid_reg || c_ready;
    assign cand_ready = b_ready;

    assign prod = b_sy_reg * cfg.scr_w;
    assign sum  = {1'b0, prod} + SUM_W'(b_sx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
                b_valid_reg <= cand_valid && visible;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && cand_valid)
        begin
            // used only when inside the window, where the coordinates are non-negative
            b_sx_reg    <= cand_sx[rsb_pkg::SCR_W-1:0];
            b_sy_reg    <= cand_sy[rsb_pkg::SCR_W-1:0];
            b_pixel_reg <= cand_pixel;
        end
        if (c_ready && b_valid_reg)
        begin
            c_addr_reg  <= ADDR_BITS'(sum);
            c_pixel_reg <= b_pixel_reg;
            c_op_reg    <= rsb_pkg::blend_code(cfg.blend);
        end
    end

    assign results.valid    = c_valid_reg;
    assign results.address  = c_addr_reg;
    assign results.pixel    = c_pixel_reg;
    assign results.blend_op = c_op_reg;

    `include "assert_macros.svh"

    `ASSERT_IMPLIES(a_op_legal, c_valid_reg,
        c_op_reg == rsb_pkg::BLEND_SOLID || c_op_reg == rsb_pkg::BLEND_GLASS_SRC ||
        c_op_reg == rsb_pkg::BLEND_GLASS_DST, "undefined blend code on output")
    `ASSERT_NEXT(a_visible_taken, cand_valid && cand_ready && visible, b_valid_reg,
        "visible pixel dropped at clip stage")
    `ASSERT_IMPLIES(a_clip_x, b_valid_reg, END_W'(b_sx_reg) < x_end,
        "clipped pixel right of window")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for rle_sprite_blitter: a queued driver, a result monitor and a
// behavioral predictor of the sprite decoder, run under several window and blend settings.
// Depends on rsb_pkg, rsb_if and the blitter RTL.

module tb;

    localparam int COORD_BITS = 12;
    localparam int ADDR_BITS  = 24;
    localparam int LATENCY    = 3;
    localparam int IDLE_LIMIT = 2000;
    localparam int COL_MAX    = (1 << (COORD_BITS + 1)) - 1;
    localparam int ROW_MASK   = (1 << COORD_BITS) - 1;
    localparam int MAX_REPORTS = 10;

    localparam logic [rsb_pkg::PIXEL_BITS-1:0] END_OF_ROW   = 8'h00;
    localparam logic [1:0]                     BLEND_UNUSED = 2'd3;

    typedef struct {
        logic                                mode;
        logic signed [rsb_pkg::POS_BITS-1:0] pos_x;
        logic signed [rsb_pkg::POS_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0]               spr_w;
        logic [COORD_BITS-1:0]               spr_h;
        logic [rsb_pkg::PIXEL_BITS-1:0]      data;
    } sprite_item_t;

    typedef struct {
        logic [ADDR_BITS-1:0]           address;
        logic [rsb_pkg::PIXEL_BITS-1:0] pixel;
        rsb_pkg::blend_t                blend_op;
    } fb_write_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           wr_en;
    logic [rsb_pkg::REG_IDX_W-1:0]  wr_index;
    logic [rsb_pkg::CFG_DATA_W-1:0] wr_data;

    rsb_in_if  #(.COORD_BITS(COORD_BITS)) items_if ();
    rsb_out_if #(.ADDR_BITS(ADDR_BITS))   writes_if ();

    rle_sprite_blitter #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items_if),
        .results  (writes_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // decoder copy kept in step with accepted items
    rsb_pkg::cfg_t cfg_shadow;
    logic blit_active;
    int   row_idx;
    int   col_idx;
    logic in_run;
    int   run_left;
    int   org_x;
    int   org_y;
    int   cur_w;
    int   cur_h;

    sprite_item_t pending_items[$];
    fb_write_t    expected_writes[$];
    sprite_item_t bus_item;
    fb_write_t    oldest_write;

    int src_gap_max   = 0;
    int snk_stall_max = 0;
    int src_gap       = 0;
    int snk_stall     = 0;
    int items_left    = 0;
    int n_queued      = 0;
    int n_accepted    = 0;
    int n_writes      = 0;
    int n_settings    = 0;
    int n_errors      = 0;
    int idle_cycles   = 0;

    function automatic void log_error(string msg);
        if (n_errors < MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        n_errors++;
    endfunction

    function automatic void place_pixel(logic [rsb_pkg::PIXEL_BITS-1:0] pix);
        int dx;
        int dy;
        int sx;
        int sy;
        longint lin;
        fb_write_t w;
        if (col_idx >= cur_w || row_idx >= cur_h)
            return;
        dx = cfg_shadow.flip_h ? cur_w - 1 - col_idx : col_idx;
        dy = cfg_shadow.flip_v ? cur_h - 1 - row_idx : row_idx;
        sx = org_x + dx;
        sy = org_y + dy;
        if (sx < int'(cfg_shadow.win_x) ||
            sx >= int'(cfg_shadow.win_x) + int'(cfg_shadow.win_w))
            return;
        if (sy < int'(cfg_shadow.win_y) ||
            sy >= int'(cfg_shadow.win_y) + int'(cfg_shadow.win_h))
            return;
        lin = longint'(sy) * longint'(cfg_shadow.scr_w) + longint'(sx);
        w.address = lin[ADDR_BITS-1:0];
        w.pixel   = pix;
        case (cfg_shadow.blend)
            rsb_pkg::BLEND_GLASS_SRC: w.blend_op = rsb_pkg::BLEND_GLASS_SRC;
            rsb_pkg::BLEND_GLASS_DST: w.blend_op = rsb_pkg::BLEND_GLASS_DST;
            default:                  w.blend_op = rsb_pkg::BLEND_SOLID;
        endcase
        expected_writes.push_back(w);
    endfunction

    function automatic void decode_item(sprite_item_t it);
        if (it.mode == rsb_pkg::MODE_START)
        begin
            org_x       = int'(cfg_shadow.win_x) + int'(it.pos_x);
            org_y       = int'(cfg_shadow.win_y) + int'(it.pos_y);
            cur_w       = int'(it.spr_w);
            cur_h       = int'(it.spr_h);
            row_idx     = 0;
            col_idx     = 0;
            in_run      = 1'b0;
            run_left    = 0;
            blit_active = (cur_w != 0) && (cur_h != 0);
        end
        else if (blit_active)
        begin
            if (in_run)
            begin
                place_pixel(it.data);
                if (col_idx < COL_MAX)
                    col_idx++;
                run_left = (run_left - 1) & 'h7F;
                if (run_left == 0)
                    in_run = 1'b0;
            end
            else if (it.data == END_OF_ROW)
            begin
                col_idx = 0;
                row_idx = (row_idx + 1) & ROW_MASK;
                if (row_idx >= cur_h || row_idx == 0)
                    blit_active = 1'b0;
            end
            else if (it.data < 8'h80)
            begin
                in_run   = 1'b1;
                run_left = int'(it.data);
            end
            else
            begin
                // negative token: skip transparent columns, count saturates
                col_idx += 256 - int'(it.data);
                if (col_idx > COL_MAX)
                    col_idx = COL_MAX;
            end
        end
    endfunction

    function automatic void push_start(int px, int py, int w, int h);
        sprite_item_t it;
        it.mode  = rsb_pkg::MODE_START;
        it.pos_x = px[rsb_pkg::POS_BITS-1:0];
        it.pos_y = py[rsb_pkg::POS_BITS-1:0];
        it.spr_w = w[COORD_BITS-1:0];
        it.spr_h = h[COORD_BITS-1:0];
        it.data  = rsb_pkg::PIXEL_BITS'($urandom_range(0, 255));
        pending_items.push_back(it);
        items_left++;
        n_queued++;
    endfunction

    function automatic void push_data(logic [rsb_pkg::PIXEL_BITS-1:0] b);
        sprite_item_t it;
        it.mode  = rsb_pkg::MODE_DATA;
        it.pos_x = rsb_pkg::POS_BITS'($urandom_range(0, 65535));
        it.pos_y = rsb_pkg::POS_BITS'($urandom_range(0, 65535));
        it.spr_w = COORD_BITS'($urandom_range(0, 4095));
        it.spr_h = COORD_BITS'($urandom_range(0, 4095));
        it.data  = b;
        pending_items.push_back(it);
        items_left++;
        n_queued++;
    endfunction

    // well-formed sprite; rows_max below h leaves it unfinished
    task automatic queue_sprite(int px, int py, int w, int h, int rows_max);
        int r;
        int col;
        int n;
        int room;
        push_start(px, py, w, h);
        for (r = 0; r < h && r < rows_max; r++)
        begin
            col = 0;
            while (col < w)
            begin
                room = w - col;
                if (room > 24 || $urandom_range(0, 3) == 0)
                begin
                    n = $urandom_range(1, (room > 128) ? 128 : room);
                    push_data(rsb_pkg::PIXEL_BITS'(256 - n));
                end
                else
                begin
                    // sometimes run past the right edge of the sprite
                    n = $urandom_range(1, room + (($urandom_range(0, 7) == 0) ? 2 : 0));
                    push_data(rsb_pkg::PIXEL_BITS'(n));
                    repeat (n) push_data(rsb_pkg::PIXEL_BITS'($urandom_range(0, 255)));
                end
                col += n;
            end
            push_data(END_OF_ROW);
        end
    endtask

    task automatic queue_random_traffic(int target);
        int stop_at;
        int pick;
        int w;
        int h;
        int span_x;
        int span_y;
        stop_at = n_queued + target;
        span_x  = (cfg_shadow.win_w > 40) ? 40 : int'(cfg_shadow.win_w);
        span_y  = (cfg_shadow.win_h > 30) ? 30 : int'(cfg_shadow.win_h);
        while (n_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 5);
                queue_sprite(int'($urandom_range(0, span_x + 8)) - 6,
                             int'($urandom_range(0, span_y + 6)) - 4, w, h, h);
            end
            else if (pick < 82)
            begin
                h = $urandom_range(2, 5);
                queue_sprite(int'($urandom_range(0, span_x + 4)) - 2,
                             int'($urandom_range(0, span_y + 4)) - 2,
                             $urandom_range(1, 12), h, $urandom_range(0, h - 1));
                if ($urandom_range(0, 1) == 1)
                begin
                    // cut off in the middle of a pixel run
                    push_data(rsb_pkg::PIXEL_BITS'($urandom_range(2, 6)));
                    push_data(rsb_pkg::PIXEL_BITS'($urandom_range(0, 255)));
                end
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 6))
                    push_data(rsb_pkg::PIXEL_BITS'($urandom_range(0, 255)));
            end
            else if (pick < 94)
            begin
                push_start($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 4095), $urandom_range(0, 4095));
                repeat ($urandom_range(0, 4))
                    push_data(rsb_pkg::PIXEL_BITS'($urandom_range(0, 255)));
            end
            else if (pick < 97)
            begin
                w = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 9);
                h = (w == 0) ? $urandom_range(0, 9) : 0;
                push_start($urandom_range(0, 8), $urandom_range(0, 8), w, h);
                repeat ($urandom_range(1, 3))
                    push_data(rsb_pkg::PIXEL_BITS'($urandom_range(1, 5)));
            end
            else
            begin
                queue_sprite(-int'($urandom_range(0, 2000)), $urandom_range(0, span_y),
                             $urandom_range(1000, 4095), $urandom_range(1, 2), 2);
            end
        end
    endtask

    task automatic write_reg(rsb_pkg::reg_idx_t idx, int value);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value[rsb_pkg::CFG_DATA_W-1:0];
        case (idx)
            rsb_pkg::REG_WINDOW_X:      cfg_shadow.win_x  = value[rsb_pkg::WIN_POS_W-1:0];
            rsb_pkg::REG_WINDOW_Y:      cfg_shadow.win_y  = value[rsb_pkg::WIN_POS_W-1:0];
            rsb_pkg::REG_WINDOW_WIDTH:  cfg_shadow.win_w  = value[rsb_pkg::WIN_SIZE_W-1:0];
            rsb_pkg::REG_WINDOW_HEIGHT: cfg_shadow.win_h  = value[rsb_pkg::WIN_SIZE_W-1:0];
            rsb_pkg::REG_SCREEN_WIDTH:  cfg_shadow.scr_w  = value[rsb_pkg::WIN_SIZE_W-1:0];
            rsb_pkg::REG_FLIP_H:        cfg_shadow.flip_h = value[0];
            rsb_pkg::REG_FLIP_V:        cfg_shadow.flip_v = value[0];
            rsb_pkg::REG_BLEND_MODE:    cfg_shadow.blend  = value[1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int wx, int wy, int ww, int wh, int sw,
                                 int fh, int fv, int bm);
        write_reg(rsb_pkg::REG_WINDOW_X, wx);
        write_reg(rsb_pkg::REG_WINDOW_Y, wy);
        write_reg(rsb_pkg::REG_WINDOW_WIDTH, ww);
        write_reg(rsb_pkg::REG_WINDOW_HEIGHT, wh);
        write_reg(rsb_pkg::REG_SCREEN_WIDTH, sw);
        write_reg(rsb_pkg::REG_FLIP_H, fh);
        write_reg(rsb_pkg::REG_FLIP_V, fv);
        write_reg(rsb_pkg::REG_BLEND_MODE, bm);
        @(posedge clk);
        wr_en <= 1'b0;
        n_settings++;
    endtask

    // sender holds off until every outstanding write has come back
    task automatic wait_idle();
        while (items_left != 0 || expected_writes.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic run_phase(int target, int gap_max, int stall_max);
        src_gap_max   = gap_max;
        snk_stall_max = stall_max;
        queue_random_traffic(target);
        wait_idle();
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_if.valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (items_if.valid && items_if.ready)
            begin
                decode_item(bus_item);
                items_left--;
                n_accepted++;
            end
            if (!items_if.valid || items_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    items_if.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    bus_item = pending_items.pop_front();
                    items_if.valid         <= 1'b1;
                    items_if.mode          <= bus_item.mode;
                    items_if.pos_x         <= bus_item.pos_x;
                    items_if.pos_y         <= bus_item.pos_y;
                    items_if.sprite_width  <= bus_item.spr_w;
                    items_if.sprite_height <= bus_item.spr_h;
                    items_if.data_byte     <= bus_item.data;
                    src_gap = $urandom_range(0, src_gap_max);
                end
                else
                begin
                    items_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            writes_if.ready <= 1'b0;
            snk_stall = 0;
        end
        else
        begin
            if (writes_if.valid && writes_if.ready)
            begin
                n_writes++;
                if (expected_writes.size() == 0)
                begin
                    log_error($sformatf("unexpected write addr=%h pixel=%h op=%0d",
                                        writes_if.address, writes_if.pixel,
                                        writes_if.blend_op));
                end
                else
                begin
                    oldest_write = expected_writes.pop_front();
                    if (writes_if.address !== oldest_write.address ||
                        writes_if.pixel !== oldest_write.pixel ||
                        writes_if.blend_op !== oldest_write.blend_op)
                        log_error($sformatf({"write mismatch: exp addr=%h pixel=%h op=%0d,",
                                             " got addr=%h pixel=%h op=%0d"},
                                            oldest_write.address, oldest_write.pixel,
                                            oldest_write.blend_op, writes_if.address,
                                            writes_if.pixel, writes_if.blend_op));
                end
                snk_stall = $urandom_range(0, snk_stall_max);
            end
            if (snk_stall > 0)
            begin
                snk_stall--;
                writes_if.ready <= 1'b0;
            end
            else
            begin
                writes_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((items_if.valid && items_if.ready) || (writes_if.valid && writes_if.ready)
                || wr_en)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: idle for %0d cycles, %0d items and %0d writes pending",
                         IDLE_LIMIT, items_left, expected_writes.size());
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        wr_en                  = 1'b0;
        wr_index               = rsb_pkg::REG_WINDOW_X;
        wr_data                = '0;
        items_if.valid         = 1'b0;
        items_if.mode          = rsb_pkg::MODE_DATA;
        items_if.pos_x         = '0;
        items_if.pos_y         = '0;
        items_if.sprite_width  = '0;
        items_if.sprite_height = '0;
        items_if.data_byte     = '0;
        writes_if.ready        = 1'b0;
        cfg_shadow             = rsb_pkg::CFG_RESET;
        blit_active            = 1'b0;
        row_idx                = 0;
        col_idx                = 0;
        in_run                 = 1'b0;
        run_left               = 0;
        org_x                  = 0;
        org_y                  = 0;
        cur_w                  = 0;
        cur_h                  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, no idling
        push_data(8'h05);                       // data with no sprite
        push_start(3, 3, 0, 5);                 // zero width
        push_data(8'h01);
        push_start(3, 3, 5, 0);                 // zero height
        push_start(10, 20, 4, 2);
        push_data(8'h03);
        push_data(8'h00);
        push_data(8'hFF);
        push_data(8'h5A);
        push_data(END_OF_ROW);
        push_data(8'h80);                       // skip of 128 columns
        push_data(8'h02);                       // pixels beyond the width
        push_data(8'h11);
        push_data(8'h22);
        push_data(END_OF_ROW);
        push_start(318, -1, 4, 2);              // clipped right and top
        push_data(8'hFF);
        push_data(8'h03);
        push_data(8'h01);
        push_data(8'h02);
        push_data(8'h03);
        push_start(32767, -32768, 1, 1);        // restart while active, fully clipped
        push_data(8'h01);
        push_data(8'h77);
        wait_idle();

        apply_setting(100, 50, 64, 48, 640, 1, 0, rsb_pkg::BLEND_GLASS_SRC);
        run_phase(50, 8, 8);
        apply_setting(4095, 4095, 4096, 4096, 4096, 1, 1, rsb_pkg::BLEND_GLASS_DST);
        run_phase(50, 0, 8);
        apply_setting(0, 0, 0, 0, 1, 0, 1, BLEND_UNUSED);
        run_phase(30, 8, 0);
        apply_setting(5, 7, 1, 1, 13, 0, 0, BLEND_UNUSED);
        run_phase(30, 3, 3);
        repeat (2)
        begin
            apply_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(1, 4096), $urandom_range(1, 4096),
                          $urandom_range(1, 4096), $urandom_range(0, 1),
                          $urandom_range(0, 1), $urandom_range(0, 3));
            run_phase(55, $urandom_range(0, 8), $urandom_range(0, 8));
        end
        apply_setting(0, 0, 320, 200, 320, 0, 0, rsb_pkg::BLEND_SOLID);
        run_phase(50, 8, 8);

        if (expected_writes.size() != 0)
            log_error($sformatf("%0d writes never arrived", expected_writes.size()));
        $display("Summary: %0d sprite items accepted under %0d register settings",
                 n_accepted, n_settings + 1);
        $display("Summary: %0d writes checked, %0d errors", n_writes, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
